// ----- rtl/srbc_pkg.sv -----
package srbc_pkg;

  // Field and register widths
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned PPT_W      = 20;
  localparam int unsigned THR_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned WHEEL_W    = 26;
  localparam int unsigned PULSE_W    = 11;
  localparam int unsigned MODE_W     = 2;

  // Serial arithmetic unit
  localparam int unsigned ACC_W     = 66;  // shift-add accumulator
  localparam int unsigned MPL_W     = 20;  // multiplier shift register
  localparam int unsigned DIV_W     = 48;  // dividend / quotient shift register
  localparam int unsigned DSR_W     = 10;  // divisor and partial remainder
  localparam int unsigned CNT_W     = $clog2(DIV_W);
  localparam int unsigned TQ_MAG_W  = 45;  // |torque| < 2^44
  localparam int unsigned DT_SHIFT  = 16;  // Q.32 -> Q.16
  localparam int unsigned PWM_SHIFT = 36;
  localparam int unsigned RAMP_SHIFT = 3;  // 800/1500 == 8/15
  localparam int unsigned RAMP_EL_W  = 11; // elapsed < 1500 while ramping

  typedef enum logic [MODE_W-1:0] {
    MODE_LYING   = 2'd0,
    MODE_SPINUP  = 2'd1,
    MODE_KICK    = 2'd2,
    MODE_BALANCE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_GAIN     = 3'd0,
    REG_RATE_GAIN      = 3'd1,
    REG_WHEEL_GAIN     = 3'd2,
    REG_PWM_PER_TORQUE = 3'd3,
    REG_LYING_THR      = 3'd4,
    REG_CATCH_THR      = 3'd5,
    REG_FALL_THR       = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TQ_ANGLE,
    ST_TQ_RATE,
    ST_TQ_WHEEL,
    ST_TQ_ABS,
    ST_MUL_DT,
    ST_DIV_K,
    ST_WSUM,
    ST_WABS,
    ST_MUL_99,
    ST_DIV_C,
    ST_CLAMP,
    ST_MUL_PWM,
    ST_PWM_CAP,
    ST_DIV_SPIN,
    ST_DONE
  } state_e;

  localparam logic [GAIN_W-1:0]  ANGLE_GAIN_RST = 18'd48497;
  localparam logic [GAIN_W-1:0]  RATE_GAIN_RST  = 18'd3932;
  localparam logic [GAIN_W-1:0]  WHEEL_GAIN_RST = 18'd328;
  localparam logic [PPT_W-1:0]   PPT_RST        = 20'd140351;
  localparam logic [THR_W-1:0]   LYING_THR_RST  = 13'd2145;
  localparam logic [THR_W-1:0]   CATCH_THR_RST  = 13'd1787;
  localparam logic [THR_W-1:0]   FALL_THR_RST   = 13'd2860;

  localparam logic [PULSE_W-1:0] PULSE_MIN  = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX  = 11'd2000;
  localparam logic [DSR_W-1:0]   PULSE_SPAN = 10'd1000;

  localparam logic [MS_W-1:0] LIE_HOLD_MS = 32'd2000;
  localparam logic [MS_W-1:0] RAMP_MS     = 32'd1500;
  localparam logic [MS_W-1:0] KICK_MS     = 32'd200;

  localparam logic [DSR_W-1:0] DSR_TICK  = 10'd1000; // us per ms
  localparam logic [DSR_W-1:0] DSR_DECAY = 10'd100;
  localparam logic [DSR_W-1:0] DSR_RAMP  = 10'd15;
  localparam logic [MPL_W-1:0] DECAY_NUM = 20'd99;

  localparam logic [WHEEL_W-1:0] WHEEL_LIMIT = 26'd32768000; // 500.0 in Q10.16

endpackage

// ----- rtl/self_righting_balance_controller.sv -----
// Channel  Dir   Handshake                 Payload
// in       sink  in_valid_i / in_stall_o   tilt_angle_i, tilt_rate_i,
//                                          tick_interval_us_i, now_ms_i
// out      src   out_valid_o / out_stall_i pulse_width_us_o, mode_o
// cfg      sink  cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. Lying, kick, crash and end-of-ramp ticks go through
// accept, decide and result. A spin-up ramp tick adds 48 divider steps.
// A balancing tick runs everything through one bit-serial unit: shift-add
// multiplies (one multiplier bit per cycle, stopping once the remaining
// bits are zero) and two 48-step restoring divides.
// Reset (async, active low) restores mode lying, start time 0, wheel
// estimate 0 and the register defaults. A waiting result in the output
// register does not block the next accept; a finished item waits only
// if the previous result is still stalled.
module self_righting_balance_controller
  import srbc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ANGLE_W-1:0]   tilt_angle_i,
  input  logic signed [ANGLE_W-1:0]   tilt_rate_i,
  input  logic        [DT_W-1:0]      tick_interval_us_i,
  input  logic        [MS_W-1:0]      now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic        [PULSE_W-1:0]   pulse_width_us_o,
  output logic        [MODE_W-1:0]    mode_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  state_e state_q, state_d;

  // config
  logic [GAIN_W-1:0] angle_gain_q, rate_gain_q, wheel_gain_q;
  logic [PPT_W-1:0]  ppt_q;
  logic [THR_W-1:0]  lying_thr_q, catch_thr_q, fall_thr_q;

  // controller state
  mode_e                     mode_q, mode_d;
  logic [MS_W-1:0]           start_q, start_d;
  logic signed [WHEEL_W-1:0] wheel_q, wheel_d;

  // latched item
  logic signed [ANGLE_W-1:0] tilt_q, rate_q;
  logic [DT_W-1:0]           dt_q;
  logic [MS_W-1:0]           now_q;

  // serial unit
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [MPL_W-1:0]        mplier_q, mplier_d;
  logic [DSR_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]        quo_q, quo_d;
  logic [DSR_W-1:0]        dsr_q, dsr_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic [TQ_MAG_W-1:0] tq_mag_q, tq_mag_d;
  logic                tq_neg_q, tq_neg_d;   // torque < 0
  logic                tq_pos_q, tq_pos_d;   // torque > 0
  logic                w_neg_q, w_neg_d;
  logic [PULSE_W-1:0]  pulse_q, pulse_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [PULSE_W-1:0] out_pulse_q, out_pulse_d;
  mode_e              out_mode_q, out_mode_d;

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic in_acc, out_free;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign in_acc           = in_valid_i && (state_q == ST_IDLE);
  assign out_free         = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign pulse_width_us_o = out_pulse_q;
  assign mode_o           = out_mode_q;
  assign cfg_ready_o      = 1'b1;

  // ---------------------------------------------------------------
  // Mode decision terms
  // ---------------------------------------------------------------
  logic [ANGLE_W-1:0] mag;
  logic [MS_W-1:0]    elapsed;
  logic over_lying, over_fall, under_catch;
  logic el_hold, el_ramp, el_kick;

  // |tilt|; -32768 maps to 0x8000 as unsigned
  assign mag         = tilt_q[ANGLE_W-1] ? ANGLE_W'(-tilt_q) : ANGLE_W'(tilt_q);
  assign elapsed     = now_q - start_q;            // wraps mod 2^32
  assign over_lying  = mag > ANGLE_W'(lying_thr_q);
  assign over_fall   = mag > ANGLE_W'(fall_thr_q);
  assign under_catch = mag < ANGLE_W'(catch_thr_q);
  assign el_hold     = elapsed > LIE_HOLD_MS;
  assign el_ramp     = elapsed < RAMP_MS;
  assign el_kick     = elapsed > KICK_MS;

  // ---------------------------------------------------------------
  // Bit-serial multiply step: one multiplier bit per cycle
  // ---------------------------------------------------------------
  logic                    mul_sub, mul_last;
  logic signed [ACC_W-1:0] mul_sum, mul_acc;

  // torque terms accumulate negated
  assign mul_sub  = (state_q == ST_TQ_ANGLE) || (state_q == ST_TQ_RATE) ||
                    (state_q == ST_TQ_WHEEL);
  assign mul_sum  = mul_sub ? acc_q - mcand_q : acc_q + mcand_q;
  assign mul_acc  = mplier_q[0] ? mul_sum : acc_q;
  assign mul_last = (mplier_q[MPL_W-1:1] == '0);

  // ---------------------------------------------------------------
  // Restoring divide step: one quotient bit per cycle
  // ---------------------------------------------------------------
  logic [DSR_W:0]   div_trial;
  logic [DSR_W+1:0] div_diff;
  logic             div_ge, div_last;
  logic [DSR_W-1:0] div_rem;
  logic [DIV_W-1:0] div_quo;

  assign div_trial = {rem_q, quo_q[DIV_W-1]};
  assign div_diff  = {1'b0, div_trial} - {2'b00, dsr_q};
  assign div_ge    = !div_diff[DSR_W+1];
  assign div_rem   = div_ge ? div_diff[DSR_W-1:0] : div_trial[DSR_W-1:0];
  assign div_quo   = {quo_q[DIV_W-2:0], div_ge};
  assign div_last  = (cnt_q == '0);

  // ---------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------
  logic signed [ACC_W-1:0]   acc_abs;
  logic signed [ACC_W-1:0]   wheel_ext;
  logic [ACC_W-1:0]          quo_ext;
  logic [WHEEL_W-1:0]        w_clamped;
  logic [ACC_W-PWM_SHIFT-1:0] pwm_off;
  logic [DSR_W-1:0]          pwm_cap;

  assign acc_abs   = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign wheel_ext = ACC_W'(wheel_q);
  assign quo_ext   = ACC_W'(quo_q);
  assign w_clamped = (quo_q > DIV_W'(WHEEL_LIMIT)) ? WHEEL_LIMIT : quo_q[WHEEL_W-1:0];
  assign pwm_off   = acc_q[ACC_W-1:PWM_SHIFT];
  assign pwm_cap   = (pwm_off > (ACC_W-PWM_SHIFT)'(PULSE_SPAN)) ? PULSE_SPAN
                                                               : pwm_off[DSR_W-1:0];

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: begin
        unique case (mode_q)
          MODE_LYING:   state_d = ST_DONE;
          MODE_SPINUP:  state_d = el_ramp ? ST_DIV_SPIN : ST_DONE;
          MODE_KICK:    state_d = ST_DONE;
          MODE_BALANCE: state_d = over_fall ? ST_DONE : ST_TQ_ANGLE;
          default:      state_d = ST_DONE;
        endcase
      end
      ST_TQ_ANGLE: if (mul_last) state_d = ST_TQ_RATE;
      ST_TQ_RATE:  if (mul_last) state_d = ST_TQ_WHEEL;
      ST_TQ_WHEEL: if (mul_last) state_d = ST_TQ_ABS;
      ST_TQ_ABS:   state_d = ST_MUL_DT;
      ST_MUL_DT:   if (mul_last) state_d = ST_DIV_K;
      ST_DIV_K:    if (div_last) state_d = ST_WSUM;
      ST_WSUM:     state_d = ST_WABS;
      ST_WABS:     state_d = ST_MUL_99;
      ST_MUL_99:   if (mul_last) state_d = ST_DIV_C;
      ST_DIV_C:    if (div_last) state_d = ST_CLAMP;
      ST_CLAMP:    state_d = tq_pos_q ? ST_MUL_PWM : ST_DONE;
      ST_MUL_PWM:  if (mul_last) state_d = ST_PWM_CAP;
      ST_PWM_CAP:  state_d = ST_DONE;
      ST_DIV_SPIN: if (div_last) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------
  always_comb begin
    mode_d      = mode_q;
    start_d     = start_q;
    wheel_d     = wheel_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dsr_d       = dsr_q;
    cnt_d       = cnt_q;
    tq_mag_d    = tq_mag_q;
    tq_neg_d    = tq_neg_q;
    tq_pos_d    = tq_pos_q;
    w_neg_d     = w_neg_q;
    pulse_d     = pulse_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pulse_d = out_pulse_q;
    out_mode_d  = out_mode_q;

    unique case (state_q)
      ST_DECIDE: begin
        pulse_d = PULSE_MIN;
        unique case (mode_q)
          MODE_LYING: begin
            // stay down long enough before trying to stand up
            if (over_lying) begin
              if (el_hold) begin
                mode_d  = MODE_SPINUP;
                start_d = now_q;
              end
            end else begin
              start_d = now_q;
            end
          end
          MODE_SPINUP: begin
            if (el_ramp) begin
              // ramp offset = elapsed*8/15
              quo_d = DIV_W'({elapsed[RAMP_EL_W-1:0], RAMP_SHIFT'(0)});
              rem_d = '0;
              dsr_d = DSR_RAMP;
              cnt_d = CNT_W'(DIV_W-1);
            end else begin
              mode_d  = MODE_KICK;
              start_d = now_q;
            end
          end
          MODE_KICK: begin
            if (el_kick || under_catch) mode_d = MODE_BALANCE;
          end
          MODE_BALANCE: begin
            if (over_fall) begin
              mode_d  = MODE_LYING;
              start_d = now_q;
            end else begin
              acc_d    = '0;
              mcand_d  = ACC_W'(tilt_q) <<< 4;
              mplier_d = MPL_W'(angle_gain_q);
            end
          end
          default: ;
        endcase
      end

      ST_TQ_ANGLE: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        if (mul_last) begin
          mcand_d  = ACC_W'(rate_q) <<< 6;
          mplier_d = MPL_W'(rate_gain_q);
        end
      end

      ST_TQ_RATE: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        if (mul_last) begin
          mcand_d  = wheel_ext;
          mplier_d = MPL_W'(wheel_gain_q);
        end
      end

      ST_TQ_WHEEL: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
      end

      ST_TQ_ABS: begin
        // acc holds torque; keep sign and magnitude, start |torque|*dt
        tq_neg_d = acc_q[ACC_W-1];
        tq_pos_d = !acc_q[ACC_W-1] && (acc_q != '0);
        tq_mag_d = acc_abs[TQ_MAG_W-1:0];
        mcand_d  = ACC_W'(acc_abs[TQ_MAG_W-1:0]);
        mplier_d = MPL_W'(dt_q);
        acc_d    = '0;
      end

      ST_MUL_DT: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        if (mul_last) begin
          // /65536000 == >>16 then /1000 on the magnitude
          quo_d = mul_acc[DT_SHIFT +: DIV_W];
          rem_d = '0;
          dsr_d = DSR_TICK;
          cnt_d = CNT_W'(DIV_W-1);
        end
      end

      ST_DIV_K, ST_DIV_C: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q - 1'b1;
      end

      ST_WSUM: begin
        acc_d = tq_neg_q ? wheel_ext - quo_ext : wheel_ext + quo_ext;
      end

      ST_WABS: begin
        // decay on the magnitude so the divide truncates toward zero
        w_neg_d  = acc_q[ACC_W-1];
        mcand_d  = acc_abs;
        mplier_d = DECAY_NUM;
        acc_d    = '0;
      end

      ST_MUL_99: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        if (mul_last) begin
          quo_d = mul_acc[DIV_W-1:0];
          rem_d = '0;
          dsr_d = DSR_DECAY;
          cnt_d = CNT_W'(DIV_W-1);
        end
      end

      ST_CLAMP: begin
        wheel_d = w_neg_q ? $signed(-w_clamped) : $signed(w_clamped);
        if (tq_pos_q) begin
          acc_d    = '0;
          mcand_d  = ACC_W'(tq_mag_q);
          mplier_d = ppt_q;
        end
      end

      ST_MUL_PWM: begin
        acc_d    = mul_acc;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
      end

      ST_PWM_CAP: begin
        pulse_d = PULSE_MIN + PULSE_W'(pwm_cap);
      end

      ST_DIV_SPIN: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q - 1'b1;
        if (div_last) pulse_d = PULSE_MIN + PULSE_W'(div_quo[DSR_W-1:0]);
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pulse_d = pulse_q;
          out_mode_d  = mode_q;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_LYING;
      start_q     <= '0;
      wheel_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      start_q     <= start_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration; unlisted indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_gain_q <= ANGLE_GAIN_RST;
      rate_gain_q  <= RATE_GAIN_RST;
      wheel_gain_q <= WHEEL_GAIN_RST;
      ppt_q        <= PPT_RST;
      lying_thr_q  <= LYING_THR_RST;
      catch_thr_q  <= CATCH_THR_RST;
      fall_thr_q   <= FALL_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ANGLE_GAIN:     angle_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_RATE_GAIN:      rate_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_WHEEL_GAIN:     wheel_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_PWM_PER_TORQUE: ppt_q        <= cfg_data_i[PPT_W-1:0];
        REG_LYING_THR:      lying_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_CATCH_THR:      catch_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_FALL_THR:       fall_thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tilt_q <= tilt_angle_i;
      rate_q <= tilt_rate_i;
      dt_q   <= tick_interval_us_i;
      now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dsr_q       <= dsr_d;
    cnt_q       <= cnt_d;
    tq_mag_q    <= tq_mag_d;
    tq_neg_q    <= tq_neg_d;
    tq_pos_q    <= tq_pos_d;
    w_neg_q     <= w_neg_d;
    pulse_q     <= pulse_d;
    out_pulse_q <= out_pulse_d;
    out_mode_q  <= out_mode_d;
  end

endmodule

// ----- rtl/srbc_checker.sv -----
module srbc_checker
  import srbc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PULSE_W-1:0] pulse_width_us_o,
  input logic [MODE_W-1:0]  mode_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pulse_width_us_o) &&
                                   $stable(mode_o))
    else $error("stalled result changed");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_width_us_o >= PULSE_MIN) && (pulse_width_us_o <= PULSE_MAX))
    else $error("pulse out of range");

  // lying and kick never drive the motor
  a_idle_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_LYING || mode_o == MODE_KICK)
      |-> pulse_width_us_o == PULSE_MIN)
    else $error("throttle not cut in lying or kick");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted two items back to back");

endmodule

bind self_righting_balance_controller srbc_checker u_srbc_checker (.*);

// ----- tb/sv/self_righting_balance_controller_test.sv -----
`timescale 1ns / 1ps

module self_righting_balance_controller_test
  import srbc_pkg::*;
;

  // Register defaults as specified for the block
  localparam logic [GAIN_W-1:0] DEF_ANGLE_GAIN = 18'd48497;
  localparam logic [GAIN_W-1:0] DEF_RATE_GAIN  = 18'd3932;
  localparam logic [GAIN_W-1:0] DEF_WHEEL_GAIN = 18'd328;
  localparam logic [PPT_W-1:0]  DEF_PPT        = 20'd140351;
  localparam logic [THR_W-1:0]  DEF_LYING_THR  = 13'd2145;
  localparam logic [THR_W-1:0]  DEF_CATCH_THR  = 13'd1787;
  localparam logic [THR_W-1:0]  DEF_FALL_THR   = 13'd2860;

  // Mode timing and pulse constants
  localparam int unsigned LIE_HOLD   = 2000;
  localparam int unsigned RAMP_LEN   = 1500;
  localparam int unsigned RAMP_RISE  = 800;
  localparam int unsigned KICK_LEN   = 200;
  localparam int unsigned PULSE_LOW  = 1000;
  localparam int unsigned PULSE_RNG  = 1000;
  localparam longint     WHEEL_CLAMP = 64'sd32768000;  // 500.0 in Q10.16
  localparam longint     DT_DIVISOR  = 64'sd65536000;  // us->ms and Q.32->Q.16

  // Only index past the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Run control
  localparam int RAND_PER_PHASE = 88;
  localparam int QUIET_LIMIT    = 5000;   // cycles without any handshake
  localparam int END_WAIT       = 400;    // > worst balancing tick
  localparam int SETTLE         = 4;

  typedef enum int {
    SET_RANDOM,
    SET_MAX,
    SET_ZERO,
    SET_MIXED,
    SET_DEFAULT
  } setting_e;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    mode_e              mode;
  } tick_result_t;

  // --------------------------------------------------------------------
  // Predictor and result store. One tick in, one result out.
  // --------------------------------------------------------------------
  class balance_predictor;
    logic [GAIN_W-1:0] angle_gain, rate_gain, wheel_gain;
    logic [PPT_W-1:0]  pwm_per_torque;
    logic [THR_W-1:0]  lying_thr, catch_thr, fall_thr;
    mode_e             mode;
    logic [MS_W-1:0]   start_ms;
    int                wheel;      // Q10.16, kept across mode changes
    tick_result_t      expected_ticks[$];
    int                errors;

    function new();
      angle_gain     = DEF_ANGLE_GAIN;
      rate_gain      = DEF_RATE_GAIN;
      wheel_gain     = DEF_WHEEL_GAIN;
      pwm_per_torque = DEF_PPT;
      lying_thr      = DEF_LYING_THR;
      catch_thr      = DEF_CATCH_THR;
      fall_thr       = DEF_FALL_THR;
      mode           = MODE_LYING;
      start_ms       = '0;
      wheel          = 0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ANGLE_GAIN:     angle_gain     = data[GAIN_W-1:0];
        REG_RATE_GAIN:      rate_gain      = data[GAIN_W-1:0];
        REG_WHEEL_GAIN:     wheel_gain     = data[GAIN_W-1:0];
        REG_PWM_PER_TORQUE: pwm_per_torque = data[PPT_W-1:0];
        REG_LYING_THR:      lying_thr      = data[THR_W-1:0];
        REG_CATCH_THR:      catch_thr      = data[THR_W-1:0];
        REG_FALL_THR:       fall_thr       = data[THR_W-1:0];
        default: ;  // dropped
      endcase
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void accept_tick(logic signed [ANGLE_W-1:0] tilt,
                              logic signed [ANGLE_W-1:0] rate,
                              logic [DT_W-1:0] dt, logic [MS_W-1:0] now);
      longint          t, r, torque, w;
      logic [MS_W-1:0] mag, elapsed;
      logic [63:0]     tq_u, prod, off;
      tick_result_t    res;
      t       = tilt;
      r       = rate;
      mag     = MS_W'((t < 0) ? -t : t);
      elapsed = now - start_ms;
      res.pulse = PULSE_W'(PULSE_LOW);
      case (mode)
        MODE_LYING: begin
          if (mag > lying_thr) begin
            if (elapsed > LIE_HOLD) begin
              mode     = MODE_SPINUP;
              start_ms = now;
            end
          end else begin
            start_ms = now;
          end
        end
        MODE_SPINUP: begin
          if (elapsed < RAMP_LEN) begin
            res.pulse = PULSE_W'(PULSE_LOW + (elapsed * RAMP_RISE) / RAMP_LEN);
          end else begin
            mode     = MODE_KICK;
            start_ms = now;
          end
        end
        MODE_KICK: begin
          // no fall test here; start time carries into balancing
          if (elapsed > KICK_LEN || mag < catch_thr) mode = MODE_BALANCE;
        end
        default: begin
          if (mag > fall_thr) begin
            mode     = MODE_LYING;
            start_ms = now;
          end else begin
            torque = -(longint'(angle_gain) * t * 16
                     + longint'(rate_gain) * r * 64
                     + longint'(wheel_gain) * longint'(wheel));
            w = longint'(wheel) + (torque * longint'(dt)) / DT_DIVISOR;
            w = (w * 99) / 100;
            if (w > WHEEL_CLAMP) w = WHEEL_CLAMP;
            if (w < -WHEEL_CLAMP) w = -WHEEL_CLAMP;
            wheel = int'(w);
            if (torque > 0) begin
              tq_u = torque;
              prod = tq_u * {44'd0, pwm_per_torque};
              off  = prod >> 36;
              if (off > PULSE_RNG) off = PULSE_RNG;
              res.pulse = PULSE_W'(PULSE_LOW + off);
            end
          end
        end
      endcase
      res.mode = mode;
      expected_ticks.push_back(res);
    endfunction

    function void check_tick(logic [PULSE_W-1:0] pulse, logic [MODE_W-1:0] md);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        $error("unexpected result: pulse_width_us %0d mode %0d", pulse, md);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      if (pulse !== want.pulse) begin
        $error("pulse_width_us: expected %0d, actual %0d", want.pulse, pulse);
        errors++;
      end
      if (md !== want.mode) begin
        $error("mode: expected %0d, actual %0d", want.mode, md);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------
  // Clock, reset, DUT signals
  // --------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i         = 1'b0;
  logic                        in_stall_o;
  logic signed [ANGLE_W-1:0]   tilt_angle_i       = '0;
  logic signed [ANGLE_W-1:0]   tilt_rate_i        = '0;
  logic        [DT_W-1:0]      tick_interval_us_i = '0;
  logic        [MS_W-1:0]      now_ms_i           = '0;
  logic                        out_valid_o;
  logic                        out_stall_i        = 1'b0;
  logic        [PULSE_W-1:0]   pulse_width_us_o;
  logic        [MODE_W-1:0]    mode_o;
  logic                        cfg_valid_i        = 1'b0;
  logic                        cfg_ready_o;
  logic        [CFG_IDX_W-1:0] cfg_index_i        = '0;
  logic        [CFG_DATA_W-1:0] cfg_data_i        = '0;

  balance_predictor sb;
  bit               idle_en = 1'b1;   // random gaps and stalls allowed
  logic [MS_W-1:0]  now_clk = '0;     // ms clock fed to the block
  int               stall_left = 0;
  int               quiet = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  self_righting_balance_controller u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .tilt_angle_i       (tilt_angle_i),
    .tilt_rate_i        (tilt_rate_i),
    .tick_interval_us_i (tick_interval_us_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pulse_width_us_o   (pulse_width_us_o),
    .mode_o             (mode_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Receiver back-pressure: random bursts of stalled cycles while idling is on.
  always @(negedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
    out_stall_i <= (stall_left > 0);
  end

  // Result monitor: every accepted result is checked against the oldest tick.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_tick(pulse_width_us_o, mode_o);
  end

  // Watchdog on handshake activity; a hang ends the run as a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------

  // One tick. Valid may stay high into the next call; a gap lowers it first.
  task automatic send_tick(logic signed [ANGLE_W-1:0] tilt,
                           logic signed [ANGLE_W-1:0] rate,
                           logic [DT_W-1:0] dt, logic [MS_W-1:0] now);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    tilt_angle_i       <= tilt;
    tilt_rate_i        <= rate;
    tick_interval_us_i <= dt;
    now_ms_i           <= now;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.accept_tick(tilt, rate, dt, now);
  endtask

  // Sender holds off until every result is back, then the block is idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Tilt strictly above / at most a threshold, random sign
  function automatic logic signed [ANGLE_W-1:0] tilt_beyond(int thr);
    int mag;
    mag = $urandom_range(32768, thr + 1);
    if ($urandom_range(0, 1)) return ANGLE_W'(-mag);
    return ANGLE_W'((mag > 32767) ? 32767 : mag);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] tilt_within(int thr);
    int mag;
    mag = $urandom_range(thr, 0);
    return ANGLE_W'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic apply_settings(setting_e which);
    logic [CFG_DATA_W-1:0] v[7];
    case (which)
      SET_MAX: begin
        // all ones: also checks masking to each register's width
        foreach (v[i]) v[i] = '1;
      end
      SET_ZERO: begin
        foreach (v[i]) v[i] = '0;
      end
      SET_MIXED: begin
        foreach (v[i]) v[i] = CFG_DATA_W'($urandom);
        v[REG_LYING_THR] = CFG_DATA_W'($urandom_range(1000, 4000));
        v[REG_CATCH_THR] = CFG_DATA_W'($urandom_range(1000, 4000));
        v[REG_FALL_THR]  = CFG_DATA_W'($urandom_range(1000, 4000));
      end
      SET_DEFAULT: begin
        v[REG_ANGLE_GAIN]     = CFG_DATA_W'(DEF_ANGLE_GAIN);
        v[REG_RATE_GAIN]      = CFG_DATA_W'(DEF_RATE_GAIN);
        v[REG_WHEEL_GAIN]     = CFG_DATA_W'(DEF_WHEEL_GAIN);
        v[REG_PWM_PER_TORQUE] = DEF_PPT;
        v[REG_LYING_THR]      = CFG_DATA_W'(DEF_LYING_THR);
        v[REG_CATCH_THR]      = CFG_DATA_W'(DEF_CATCH_THR);
        v[REG_FALL_THR]       = CFG_DATA_W'(DEF_FALL_THR);
      end
      default: begin
        foreach (v[i]) v[i] = CFG_DATA_W'($urandom);
      end
    endcase
    cfg_write(REG_ANGLE_GAIN,     v[REG_ANGLE_GAIN]);
    cfg_write(REG_RATE_GAIN,      v[REG_RATE_GAIN]);
    cfg_write(REG_WHEEL_GAIN,     v[REG_WHEEL_GAIN]);
    cfg_write(REG_PWM_PER_TORQUE, v[REG_PWM_PER_TORQUE]);
    cfg_write(REG_LYING_THR,      v[REG_LYING_THR]);
    cfg_write(REG_CATCH_THR,      v[REG_CATCH_THR]);
    cfg_write(REG_FALL_THR,       v[REG_FALL_THR]);
    // index past the list must leave every register alone
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Directed ticks under reset defaults: full journey, edges and clock wrap.
  task automatic run_directed();
    send_tick(16'sd0, 16'sd0, 16'd0, 32'd0);                  // upright, lying
    send_tick(16'sd32767, 16'sd32767, 16'hFFFF, 32'd1000);     // tilted, hold not met
    send_tick(-16'sd32768, -16'sd32768, 16'd0, 32'd3001);      // hold met: spin-up
    send_tick(16'sd100, 16'sd0, 16'd10000, 32'd3701);          // mid ramp
    send_tick(16'sd0, 16'sd0, 16'd10000, 32'd4500);            // last ramp ms
    send_tick(16'sd0, 16'sd0, 16'd10000, 32'd4501);            // ramp done: kick
    send_tick(16'sd32767, 16'sd0, 16'd10000, 32'd4601);        // kick ignores fall
    send_tick(-16'sd32768, 16'sd0, 16'd10000, 32'd4701);       // 200 ms, still kick
    send_tick(16'sd0, 16'sd0, 16'd10000, 32'd4702);            // time out: balance
    send_tick(-16'sd2000, -16'sd32768, 16'hFFFF, 32'd4712);    // saturated pulse
    send_tick(16'sd2000, 16'sd32767, 16'd0, 32'd4722);         // zero interval
    send_tick(16'sd0, 16'sd0, 16'hFFFF, 32'd4732);             // wheel feedback only
    send_tick(-16'sd2860, 16'sd0, 16'd1000, 32'd4742);         // at fall limit
    send_tick(16'sd2861, 16'sd0, 16'd1000, 32'd4752);          // crash to lying
    send_tick(16'sd0, 16'sd0, 16'd0, 32'hFFFF_FC00);           // start just before wrap
    send_tick(-16'sd4000, 16'sd0, 16'd0, 32'h0000_0400);       // hold met across wrap
    send_tick(16'sd0, 16'sd0, 16'd0, 32'h0000_0300);           // clock steps back: kick
    send_tick(16'sd0, 16'sd0, 16'd0, 32'h0000_0310);           // caught: balance
    now_clk = 32'h0000_0310;
  endtask

  // Random ticks steered by the predicted mode so most runs walk the whole
  // lying -> spin-up -> kick -> balancing cycle; about one in ten is noise.
  task automatic run_random(int count);
    logic signed [ANGLE_W-1:0] tilt, rate;
    logic [DT_W-1:0]           dt;
    int                        r;
    for (int n = 0; n < count; n++) begin
      rate = ANGLE_W'($urandom);
      dt   = DT_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        tilt = ANGLE_W'($urandom);
        now_clk += $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000);
      end else begin
        case (sb.mode)
          MODE_LYING: begin
            tilt = ($urandom_range(0, 5) != 0) ? tilt_beyond(sb.lying_thr)
                                               : tilt_within(sb.lying_thr);
            now_clk += $urandom_range(100, 700);
          end
          MODE_SPINUP: begin
            tilt = ANGLE_W'($urandom);
            now_clk += $urandom_range(50, 400);
          end
          MODE_KICK: begin
            tilt = $urandom_range(0, 1) ? tilt_within(sb.catch_thr)
                                        : ANGLE_W'($urandom);
            now_clk += $urandom_range(10, 120);
          end
          default: begin
            tilt = ($urandom_range(0, 19) == 0) ? tilt_beyond(sb.fall_thr)
                                                : tilt_within(sb.fall_thr);
            if ($urandom_range(0, 3) != 0) begin
              r    = $urandom_range(0, 8191);
              rate = ANGLE_W'(r - 4096);
              dt   = DT_W'($urandom_range(5000, 20000));
            end
            now_clk += $urandom_range(5, 50);
          end
        endcase
      end
      send_tick(tilt, rate, dt, now_clk);
    end
  endtask

  task automatic run_phase(setting_e which);
    drain();
    apply_settings(which);
    run_random(RAND_PER_PHASE);
  endtask

  // --------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random(RAND_PER_PHASE);
    run_phase(SET_RANDOM);
    run_phase(SET_MAX);
    run_phase(SET_ZERO);
    run_phase(SET_MIXED);
    idle_en = 1'b0;   // closing stretch runs at full rate on both sides
    run_phase(SET_DEFAULT);

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- self_righting_balance_controller.f -----
rtl/srbc_pkg.sv
rtl/self_righting_balance_controller.sv
rtl/srbc_checker.sv
tb/sv/self_righting_balance_controller_test.sv
